@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication in the same cycle, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// Implication in the next cycle, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/tst_pkg.sv @@
// ----------------------------------------------------------------------------
// tst_pkg
// Command codes, sequence ROM and roger tone table for the tone sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tst_pkg;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_TONE  = 2'd1;
  localparam logic [1:0] MODE_ROGER = 2'd2;
  localparam logic [1:0] MODE_SEQ   = 2'd3;

  // Sequence identifiers.
  localparam logic [1:0] SEQ_CHIME = 2'd0;
  localparam logic [1:0] SEQ_ALERT = 2'd1;
  localparam logic [1:0] SEQ_CHIRP = 2'd2;

  localparam int MAX_STEPS = 8;
  localparam int STEP_W    = 3;
  localparam int LEN_W     = 5;
  localparam logic [15:0] ROGER_DUR_MS = 16'd200;

  // Number of steps in each sequence; an unknown sequence has none.
  function automatic logic [LEN_W-1:0] seq_len(input logic [1:0] seq);
    logic [LEN_W-1:0] len;
    unique case (seq)
      SEQ_CHIME: len = LEN_W'(5);
      SEQ_ALERT: len = LEN_W'(6);
      SEQ_CHIRP: len = LEN_W'(3);
      default:   len = '0;
    endcase
    return len;
  endfunction

  // Frequency of one step in tenths of hertz; zero is a silent step.
  function automatic logic [15:0] step_freq(input logic [1:0] seq,
                                            input logic [STEP_W-1:0] idx);
    logic [15:0] f;
    f = 16'd0;
    unique case (seq)
      SEQ_CHIME: begin
        unique case (idx)
          3'd0:    f = 16'd8000;
          3'd2:    f = 16'd12000;
          3'd4:    f = 16'd16000;
          default: f = 16'd0;
        endcase
      end
      SEQ_ALERT: begin
        unique case (idx)
          3'd0, 3'd2, 3'd4: f = 16'd12000;
          3'd1, 3'd3, 3'd5: f = 16'd8000;
          default:          f = 16'd0;
        endcase
      end
      SEQ_CHIRP: begin
        unique case (idx)
          3'd0:    f = 16'd6000;
          3'd1:    f = 16'd8000;
          3'd2:    f = 16'd10000;
          default: f = 16'd0;
        endcase
      end
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  // Duration of one step in milliseconds.
  function automatic logic [15:0] step_dur(input logic [1:0] seq,
                                           input logic [STEP_W-1:0] idx);
    logic [15:0] d;
    d = 16'd0;
    unique case (seq)
      SEQ_CHIME: begin
        unique case (idx)
          3'd0, 3'd2: d = 16'd80;
          3'd1, 3'd3: d = 16'd30;
          3'd4:       d = 16'd120;
          default:    d = 16'd0;
        endcase
      end
      SEQ_ALERT: begin
        unique case (idx)
          3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5: d = 16'd100;
          default:                            d = 16'd0;
        endcase
      end
      SEQ_CHIRP: begin
        unique case (idx)
          3'd0, 3'd1: d = 16'd60;
          3'd2:       d = 16'd80;
          default:    d = 16'd0;
        endcase
      end
      default: d = 16'd0;
    endcase
    return d;
  endfunction

  // Roger beep frequency; selections above three fall back to the tone of selection zero.
  function automatic logic [15:0] roger_freq(input logic [7:0] sel);
    logic [15:0] f;
    unique case (sel)
      8'd1:    f = 16'd14500;
      8'd2:    f = 16'd17500;
      8'd3:    f = 16'd21000;
      default: f = 16'd10000;
    endcase
    return f;
  endfunction

endpackage

@@ hdl/tone_sequence_timer.sv @@
// A result word reaches the outputs through the input register and then the
// result register.
// Throughput: one word per cycle while out_ready is high; the state update is
// combinational, between the input register and the result register.
// Reset (rst, synchronous): all sequencer state cleared, beeps enabled,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// tone_sequence_timer
// Beep and tone sequencer: timed tones, roger beeps and ROM step sequences
// driven by millisecond time stamps carried with each command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tone_sequence_timer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic                       cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic [31:0]                now_ms,
  input  logic [15:0]                tone_freq,
  input  logic [15:0]                tone_length_ms,
  input  logic [7:0]                 roger_select,
  input  logic [1:0]                 sequence_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                dac_freq,
  output logic                       path_on,
  output logic                       busy_res,
  output logic [tst_pkg::STEP_W-1:0] step_now
);

  import tst_pkg::*;

  // Input register.
  logic                s1_valid;
  logic [1:0]          s1_mode;
  logic [31:0]         s1_now;
  logic [15:0]         s1_freq;
  logic [15:0]         s1_len;
  logic [7:0]          s1_rsel;
  logic [1:0]          s1_sid;
  logic                s1_move;

  // Sequencer state.
  logic                beep_enable;
  logic [31:0]         end_time;
  logic                tone_busy;
  logic                in_sequence;
  logic [1:0]          current_sequence;
  logic [STEP_W-1:0]   step_number;
  logic [15:0]         playing_freq;
  logic                route_on;

  logic [31:0]         end_time_next;
  logic                tone_busy_next;
  logic                in_sequence_next;
  logic [1:0]          current_sequence_next;
  logic [STEP_W-1:0]   step_number_next;
  logic [15:0]         playing_freq_next;
  logic                route_on_next;

  // Helper terms for the update.
  logic [LEN_W-1:0]    cur_count;
  logic [LEN_W-1:0]    step_plus;
  logic [STEP_W-1:0]   step_inc;
  logic [15:0]         nstep_freq;
  logic [15:0]         nstep_dur;
  logic [15:0]         first_freq;
  logic [15:0]         first_dur;
  logic                time_up;

  // The input register takes a word whenever it is empty or its content moves on.
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode;
      s1_now  <= now_ms;
      s1_freq <= tone_freq;
      s1_len  <= tone_length_ms;
      s1_rsel <= roger_select;
      s1_sid  <= sequence_id;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      beep_enable <= 1'b1;
    end else if (cfg_write_en) begin
      beep_enable <= cfg_write_data;
    end
  end

  // Step bookkeeping for a poll: the length is clamped to the ROM depth.
  always_comb begin
    cur_count = seq_len(current_sequence);
    if (cur_count > LEN_W'(MAX_STEPS)) begin
      cur_count = LEN_W'(MAX_STEPS);
    end
  end

  assign step_plus  = LEN_W'(step_number) + LEN_W'(1);
  assign step_inc   = step_plus[STEP_W-1:0];
  assign nstep_freq = step_freq(current_sequence, step_inc);
  assign nstep_dur  = step_dur(current_sequence, step_inc);
  assign first_freq = step_freq(s1_sid, '0);
  assign first_dur  = step_dur(s1_sid, '0);
  assign time_up    = s1_now >= end_time;

  // State update for the word held in the input register.
  always_comb begin
    end_time_next         = end_time;
    tone_busy_next        = tone_busy;
    in_sequence_next      = in_sequence;
    current_sequence_next = current_sequence;
    step_number_next      = step_number;
    playing_freq_next     = playing_freq;
    route_on_next         = route_on;
    unique case (s1_mode)
      MODE_POLL: begin
        if (tone_busy && time_up) begin
          if (in_sequence && (step_plus < cur_count)) begin
            step_number_next = step_inc;
            end_time_next    = s1_now + 32'(nstep_dur);
            if (nstep_freq != 16'd0) begin
              route_on_next     = 1'b1;
              playing_freq_next = nstep_freq;
            end else begin
              playing_freq_next = 16'd0;
            end
          end else begin
            playing_freq_next = 16'd0;
            route_on_next     = 1'b0;
            tone_busy_next    = 1'b0;
            in_sequence_next  = 1'b0;
          end
        end
      end
      MODE_TONE: begin
        if (beep_enable) begin
          route_on_next     = 1'b1;
          playing_freq_next = s1_freq;
          end_time_next     = s1_now + 32'(s1_len);
          tone_busy_next    = 1'b1;
          in_sequence_next  = 1'b0;
          step_number_next  = '0;
        end
      end
      MODE_ROGER: begin
        route_on_next     = 1'b1;
        playing_freq_next = roger_freq(s1_rsel);
        end_time_next     = s1_now + 32'(ROGER_DUR_MS);
        tone_busy_next    = 1'b1;
        in_sequence_next  = 1'b0;
        step_number_next  = '0;
      end
      MODE_SEQ: begin
        if (beep_enable && (seq_len(s1_sid) != '0)) begin
          current_sequence_next = s1_sid;
          step_number_next      = '0;
          in_sequence_next      = 1'b1;
          tone_busy_next        = 1'b1;
          end_time_next         = s1_now + 32'(first_dur);
          if (first_freq != 16'd0) begin
            route_on_next     = 1'b1;
            playing_freq_next = first_freq;
          end else begin
            playing_freq_next = 16'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers advance together with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_time         <= '0;
      tone_busy        <= 1'b0;
      in_sequence      <= 1'b0;
      current_sequence <= '0;
      step_number      <= '0;
      playing_freq     <= '0;
      route_on         <= 1'b0;
    end else if (s1_move) begin
      end_time         <= end_time_next;
      tone_busy        <= tone_busy_next;
      in_sequence      <= in_sequence_next;
      current_sequence <= current_sequence_next;
      step_number      <= step_number_next;
      playing_freq     <= playing_freq_next;
      route_on         <= route_on_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      dac_freq <= playing_freq_next;
      path_on  <= route_on_next;
      busy_res <= tone_busy_next;
      step_now <= in_sequence_next ? step_number_next : '0;
    end
  end

  // Consistency checks on the sequencer state and the pipeline handshake.
  `ASSERT_IMPLIES(a_seq_needs_busy, clk, rst, in_sequence, tone_busy)
  `ASSERT_IMPLIES(a_freq_needs_path, clk, rst, playing_freq != 16'd0, route_on)
  `ASSERT_IMPLIES(a_step_in_range, clk, rst, in_sequence,
                  LEN_W'(step_number) < seq_len(current_sequence))
  `ASSERT_NEXT(a_move_gives_result, clk, rst, s1_move, out_valid)

endmodule
